/* sv/encoder_velocity_filter_unit_macros.svh */
// Assertion helpers for the encoder velocity filter.
// Both use the clk / rst_n names of the module that includes this file.
`ifndef ENCODER_VELOCITY_FILTER_UNIT_MACROS_SVH
`define ENCODER_VELOCITY_FILTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define EVF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define EVF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define EVF_ASSERT_IMP(lbl, ante, cons, msg)
`define EVF_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

/* sv/evf_pkg.sv */
package evf_pkg;

    // Field widths
    localparam int WORD_W    = 16;
    localparam int ANGLE_W   = 14;
    localparam int STEP_W    = 15;
    localparam int CNT_W     = 23;
    localparam int RAD_W     = 21;
    localparam int COEF_W    = 16;
    localparam int CFG_IDX_W = 4;

    // Shared multiplier: signed A times unsigned Q0.16 coefficient
    localparam int MUL_A_W = 24;
    localparam int PROD_W  = MUL_A_W + COEF_W + 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_WEIGHT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAD_SCALE     = 4'd1;

    // Register reset values
    localparam logic [COEF_W-1:0] FILTER_WEIGHT_RST = 16'd13107;
    localparam logic [COEF_W-1:0] RAD_SCALE_RST     = 16'd25133;

    // Angle wrap limits
    localparam logic signed [WORD_W-1:0] HALF_TURN = 16'sd8192;
    localparam logic signed [WORD_W-1:0] FULL_TURN = 16'sd16384;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RAD,
        ST_EMA_C,
        ST_EMA_R,
        ST_UPD_R
    } evf_state_t;

    // Request to the shared multiplier
    typedef struct packed {
        logic                       load;
        logic signed [MUL_A_W-1:0]  a;
        logic [COEF_W-1:0]          b;
    } evf_mul_req_t;

endpackage

/* sv/evf_mul.sv */
module evf_mul (
    input  logic                                clk,
    input  evf_pkg::evf_mul_req_t               req,
    output logic signed [evf_pkg::PROD_W-1:0]   prod
);
    import evf_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] a_ext;
    logic signed [PROD_W-1:0] b_ext;

    // Operands brought to the product width; the coefficient is unsigned
    assign a_ext = {{(PROD_W-MUL_A_W){req.a[MUL_A_W-1]}}, req.a};
    assign b_ext = {{(PROD_W-COEF_W){1'b0}}, req.b};

    // Registered signed product (24x17 significant bits)
    always_ff @(posedge clk)
    begin
        if (req.load)
        begin
            prod_reg <= a_ext * b_ext;
        end
    end

    assign prod = prod_reg;

endmodule

/* sv/encoder_velocity_filter_unit.sv */
// Channel   Dir  Handshake           Payload
// input     in   in_valid/in_stall   sensor_word_one, sensor_word_two
// result    out  out_valid/out_stall angle_*, step_*, speed_counts_*, speed_radians_*
// config    in   cfg_write           cfg_index, cfg_data
//
// A transaction is an accept, then four steps per encoder
// on a single shared 24x17 registered multiplier (rad target, two average updates).
// in_stall is high from accept until the last step finishes.
// Reset (async, active low) zeroes previous angles and averages and loads the
// default weight and scale. A held result (out_valid with out_stall) delays only
// the final step; the result register frees the input side once it is taken.
module encoder_velocity_filter_unit (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_write,
    input  logic [evf_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [evf_pkg::COEF_W-1:0]               cfg_data,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic [evf_pkg::WORD_W-1:0]               sensor_word_one,
    input  logic [evf_pkg::WORD_W-1:0]               sensor_word_two,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic [evf_pkg::ANGLE_W-1:0]              angle_one,
    output logic [evf_pkg::ANGLE_W-1:0]              angle_two,
    output logic signed [evf_pkg::STEP_W-1:0]        step_one,
    output logic signed [evf_pkg::STEP_W-1:0]        step_two,
    output logic signed [evf_pkg::CNT_W-1:0]         speed_counts_one,
    output logic signed [evf_pkg::CNT_W-1:0]         speed_counts_two,
    output logic signed [evf_pkg::RAD_W-1:0]         speed_radians_one,
    output logic signed [evf_pkg::RAD_W-1:0]         speed_radians_two
);
    import evf_pkg::*;

    `include "encoder_velocity_filter_unit_macros.svh"

    // Configuration
    logic [COEF_W-1:0] filter_weight_reg;
    logic [COEF_W-1:0] rad_scale_reg;

    // Sequencer
    evf_state_t state_reg, state_next;
    logic       lane_reg, lane_next;

    // Per-encoder state and working values
    logic [ANGLE_W-1:0]        prev_reg  [2];
    logic signed [CNT_W-1:0]   avg_c_reg [2];
    logic signed [RAD_W-1:0]   avg_r_reg [2];
    logic [ANGLE_W-1:0]        angle_reg [2];
    logic signed [STEP_W-1:0]  step_reg  [2];
    logic signed [RAD_W-1:0]   tr_reg;

    // Result register
    logic                      out_valid_reg, out_valid_next;
    logic [ANGLE_W-1:0]        o_angle_reg [2];
    logic signed [STEP_W-1:0]  o_step_reg  [2];
    logic signed [CNT_W-1:0]   o_cnt_reg   [2];
    logic signed [RAD_W-1:0]   o_rad_reg   [2];

    // Datapath wires
    logic                      accept;
    logic                      out_free;
    logic                      load_out;
    logic [ANGLE_W-1:0]        new_angle [2];
    logic signed [STEP_W-1:0]  new_step  [2];
    evf_mul_req_t              mul_req;
    logic signed [PROD_W-1:0]  prod;
    logic signed [MUL_A_W-1:0] prod_q16;
    logic signed [MUL_A_W-1:0] tc;
    logic signed [MUL_A_W-1:0] cnt_sum;
    logic signed [MUL_A_W-1:0] rad_sum;
    logic signed [CNT_W-1:0]   avg_c_new;
    logic signed [RAD_W-1:0]   avg_r_new;
    logic signed [RAD_W-1:0]   tr_sat;

    // Shared multiplier
    evf_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    // Angle extraction and wrapped difference, both encoders at accept
    function automatic logic signed [STEP_W-1:0] wrap_step(
        input logic [ANGLE_W-1:0] cur,
        input logic [ANGLE_W-1:0] prv
    );
        logic signed [WORD_W-1:0] diff;
        diff = $signed({2'b00, cur}) - $signed({2'b00, prv});
        if (diff > HALF_TURN)
        begin
            diff = diff - FULL_TURN;
        end
        else if (diff < -HALF_TURN)
        begin
            diff = diff + FULL_TURN;
        end
        return diff[STEP_W-1:0];
    endfunction

    assign new_angle[0] = sensor_word_one[WORD_W-1:2];
    assign new_angle[1] = sensor_word_two[WORD_W-1:2];
    assign new_step[0]  = wrap_step(new_angle[0], prev_reg[0]);
    assign new_step[1]  = wrap_step(new_angle[1], prev_reg[1]);

    // Product scaling and averaging adds
    assign prod_q16  = prod[MUL_A_W+15:16];
    assign tc        = {step_reg[lane_reg][STEP_W-1], step_reg[lane_reg], 8'b0};
    assign cnt_sum   = MUL_A_W'(avg_c_reg[lane_reg]) + prod_q16;
    assign rad_sum   = MUL_A_W'(avg_r_reg[lane_reg]) + prod_q16;
    assign avg_c_new = cnt_sum[CNT_W-1:0];
    assign avg_r_new = rad_sum[RAD_W-1:0];

    // Radians target: floor(d * s / 256), saturated to the field width
    always_comb
    begin
        if ((&prod[PROD_W-1:RAD_W+7]) || !(|prod[PROD_W-1:RAD_W+7]))
        begin
            tr_sat = prod[RAD_W+7:8];
        end
        else if (prod[PROD_W-1])
        begin
            tr_sat = {1'b1, {(RAD_W-1){1'b0}}};
        end
        else
        begin
            tr_sat = {1'b0, {(RAD_W-1){1'b1}}};
        end
    end

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // Sequencer and multiplier operand selection
    always_comb
    begin
        state_next   = state_reg;
        lane_next    = lane_reg;
        load_out     = 1'b0;
        mul_req.load = 1'b0;
        mul_req.a    = '0;
        mul_req.b    = filter_weight_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RAD;
                    lane_next  = 1'b0;
                end
            end
            ST_RAD:
            begin
                mul_req.load = 1'b1;
                mul_req.a    = MUL_A_W'(step_reg[lane_reg]);
                mul_req.b    = rad_scale_reg;
                state_next   = ST_EMA_C;
            end
            ST_EMA_C:
            begin
                mul_req.load = 1'b1;
                mul_req.a    = tc - MUL_A_W'(avg_c_reg[lane_reg]);
                state_next   = ST_EMA_R;
            end
            ST_EMA_R:
            begin
                mul_req.load = 1'b1;
                mul_req.a    = MUL_A_W'(tr_reg) - MUL_A_W'(avg_r_reg[lane_reg]);
                state_next   = ST_UPD_R;
            end
            ST_UPD_R:
            begin
                if (!lane_reg)
                begin
                    lane_next  = 1'b1;
                    state_next = ST_RAD;
                end
                else if (out_free)
                begin
                    load_out   = 1'b1;
                    lane_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid tracking
    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            lane_reg          <= 1'b0;
            out_valid_reg     <= 1'b0;
            filter_weight_reg <= FILTER_WEIGHT_RST;
            rad_scale_reg     <= RAD_SCALE_RST;
            prev_reg[0]       <= '0;
            prev_reg[1]       <= '0;
            avg_c_reg[0]      <= '0;
            avg_c_reg[1]      <= '0;
            avg_r_reg[0]      <= '0;
            avg_r_reg[1]      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            lane_reg      <= lane_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write && (cfg_index == REG_FILTER_WEIGHT))
            begin
                filter_weight_reg <= cfg_data;
            end
            if (cfg_write && (cfg_index == REG_RAD_SCALE))
            begin
                rad_scale_reg <= cfg_data;
            end
            if (accept)
            begin
                prev_reg[0] <= new_angle[0];
                prev_reg[1] <= new_angle[1];
            end
            if (state_reg == ST_EMA_R)
            begin
                avg_c_reg[lane_reg] <= avg_c_new;
            end
            if ((state_reg == ST_UPD_R) && (!lane_reg || out_free))
            begin
                avg_r_reg[lane_reg] <= avg_r_new;
            end
        end
    end

    // Working payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            angle_reg[0] <= new_angle[0];
            angle_reg[1] <= new_angle[1];
            step_reg[0]  <= new_step[0];
            step_reg[1]  <= new_step[1];
        end
        if (state_reg == ST_EMA_C)
        begin
            tr_reg <= tr_sat;
        end
    end

    // Result payload register; encoder two's rad average comes straight in
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            o_angle_reg[0] <= angle_reg[0];
            o_angle_reg[1] <= angle_reg[1];
            o_step_reg[0]  <= step_reg[0];
            o_step_reg[1]  <= step_reg[1];
            o_cnt_reg[0]   <= avg_c_reg[0];
            o_cnt_reg[1]   <= avg_c_reg[1];
            o_rad_reg[0]   <= avg_r_reg[0];
            o_rad_reg[1]   <= avg_r_new;
        end
    end

    assign in_stall          = (state_reg != ST_IDLE);
    assign out_valid         = out_valid_reg;
    assign angle_one         = o_angle_reg[0];
    assign angle_two         = o_angle_reg[1];
    assign step_one          = o_step_reg[0];
    assign step_two          = o_step_reg[1];
    assign speed_counts_one  = o_cnt_reg[0];
    assign speed_counts_two  = o_cnt_reg[1];
    assign speed_radians_one = o_rad_reg[0];
    assign speed_radians_two = o_rad_reg[1];

    // Checks
    `EVF_ASSERT_NXT(a_accept_starts, accept, (state_reg == ST_RAD) && !lane_reg, "accept did not start encoder one")
    `EVF_ASSERT_NXT(a_finish_presents, (state_reg == ST_UPD_R) && lane_reg && out_free, out_valid && (state_reg == ST_IDLE), "finished transaction not presented")
    `EVF_ASSERT_IMP(a_step_range, out_valid, (step_one >= -15'sd8192) && (step_one <= 15'sd8192) && (step_two >= -15'sd8192) && (step_two <= 15'sd8192), "step outside half turn")
    `EVF_ASSERT_IMP(a_ema_order, state_reg == ST_EMA_C, $past(state_reg) == ST_RAD, "average step out of order")

endmodule
